### design/modbus_stepper_frame_builder_assert.svh
// Assertion macros for the stepper frame builder checker
`ifndef MODBUS_STEPPER_FRAME_BUILDER_ASSERT_SVH
`define MODBUS_STEPPER_FRAME_BUILDER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define MSFB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame builder check failed");

// next-cycle implication, sampled on clk, off during rst
`define MSFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame builder check failed");

`endif

### design/msfb_pkg.sv
// Types and constants shared by the stepper frame builder
`timescale 1ns / 1ps
package msfb_pkg;

  localparam int FRAME_LEN = 41;
  localparam int CRC_SPAN  = 39;
  localparam int IDX_W     = 6;

  localparam logic [7:0]  FUNC_WRITE_MULTI = 8'h10;
  localparam logic [7:0]  REG_START_LO     = 8'h58;
  localparam logic [7:0]  REG_COUNT_LO     = 8'h10;
  localparam logic [7:0]  DATA_BYTE_COUNT  = 8'h20;
  localparam logic [7:0]  TRIGGER_LO       = 8'h01;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;

  localparam logic [1:0]  MODE_ABSOLUTE    = 2'd1;
  localparam logic [1:0]  MODE_RELATIVE    = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  typedef logic [9:0] current_t;
  localparam current_t RUN_CURRENT_RESET = 10'd1000;

  typedef struct packed {
    logic [7:0]         motor_address;
    logic               relative_mode;
    logic signed [31:0] target_position;
    logic [31:0]        top_speed;
    logic [31:0]        start_slope;
    logic [31:0]        stop_slope;
  } cmd_t;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic [IDX_W-1:0] byte_index;
    logic             last_byte;
  } res_t;

  typedef struct packed {
    logic [7:0]  address;
    logic [1:0]  mode_word;
    logic [31:0] position;
    logic [31:0] speed;
    logic [31:0] start_slope;
    logic [31:0] stop_slope;
    current_t    run_current;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

### design/msfb_chan_if.sv
// Valid/ready channel interface carrying one payload
`timescale 1ns / 1ps
interface msfb_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/modbus_stepper_frame_builder.sv
// Top level of the Modbus RTU stepper frame builder
//
//   channel  dir  payload                          request
//   cmd      in   msfb_pkg::cmd_t                  one stepper command
//   res      out  msfb_pkg::res_t                  one frame byte
//   cfg      in   msfb_pkg::current_t              run current write
//
// Each command yields 41 bytes, one per cycle while res is ready.
// Commands queue up to QUEUE_DEPTH deep, the frame in progress included;
// frames run back to back with no gap. The first byte of a frame passes
// through a queue entry and then the byte-wide output register of the back end.
// Synchronous reset clears the queue, the byte counter and restores the
// run current to 1000. A stalled res holds its byte; the back end waits.
`timescale 1ns / 1ps
module modbus_stepper_frame_builder #(
  parameter int QUEUE_DEPTH = 2
) (
  input logic       clk,
  input logic       rst,
  msfb_chan_if.sink   cmd,
  msfb_chan_if.source res,
  msfb_chan_if.sink   cfg
);

  msfb_pkg::job_t      push_job;
  msfb_pkg::job_t      head_job;
  msfb_pkg::q_status_t q_status;
  logic                push;
  logic                pop;

  msfb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_payload (cmd.payload),
    .cfg_valid   (cfg.valid),
    .cfg_ready   (cfg.ready),
    .cfg_payload (cfg.payload),
    .q_status    (q_status),
    .push        (push),
    .job         (push_job)
  );

  msfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head_job),
    .status   (q_status)
  );

  msfb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .job         (head_job),
    .pop         (pop),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_payload (res.payload)
  );

endmodule

### design/msfb_front.sv
// Front end: config register, command accept and job classification
`timescale 1ns / 1ps
module msfb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  msfb_pkg::cmd_t      cmd_payload,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  msfb_pkg::current_t  cfg_payload,
  input  msfb_pkg::q_status_t q_status,
  output logic                push,
  output msfb_pkg::job_t      job
);

  msfb_pkg::current_t run_current;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_current <= msfb_pkg::RUN_CURRENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      run_current <= cfg_payload;
    end
  end

  assign cfg_ready = 1'b1;
  assign cmd_ready = !q_status.full;
  assign push      = cmd_valid && cmd_ready;

  always_comb begin
    job.address     = cmd_payload.motor_address;
    job.mode_word   = cmd_payload.relative_mode ? msfb_pkg::MODE_RELATIVE
                                                : msfb_pkg::MODE_ABSOLUTE;
    job.position    = cmd_payload.target_position;
    job.speed       = cmd_payload.top_speed;
    job.start_slope = cmd_payload.start_slope;
    job.stop_slope  = cmd_payload.stop_slope;
    job.run_current = run_current;
  end

endmodule

### design/msfb_queue.sv
// Short job queue between front and back
`timescale 1ns / 1ps
module msfb_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  msfb_pkg::job_t      push_job,
  input  logic                pop,
  output msfb_pkg::job_t      head,
  output msfb_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  msfb_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.valid = (count != '0);
  assign status.full  = (count == CNT_FULL);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/msfb_back.sv
// Back end: byte serializer with running CRC-16 and output register
`timescale 1ns / 1ps
module msfb_back (
  input  logic                clk,
  input  logic                rst,
  input  msfb_pkg::q_status_t q_status,
  input  msfb_pkg::job_t      job,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_ready,
  output msfb_pkg::res_t      res_payload
);

  logic [msfb_pkg::IDX_W-1:0] idx;
  logic [15:0]                crc;
  logic [15:0]                crc_next;
  logic [7:0]                 cur_byte;
  logic                       advance;
  logic                       at_last;

  function automatic logic [15:0] crc_update(logic [15:0] c_in, logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ msfb_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  always_comb begin
    unique case (idx) inside
      6'd0:                      cur_byte = job.address;
      6'd1:                      cur_byte = msfb_pkg::FUNC_WRITE_MULTI;
      6'd3:                      cur_byte = msfb_pkg::REG_START_LO;
      6'd5:                      cur_byte = msfb_pkg::REG_COUNT_LO;
      6'd6:                      cur_byte = msfb_pkg::DATA_BYTE_COUNT;
      6'd14:                     cur_byte = {6'b0, job.mode_word};
      6'd15:                     cur_byte = job.position[31:24];
      6'd16:                     cur_byte = job.position[23:16];
      6'd17:                     cur_byte = job.position[15:8];
      6'd18:                     cur_byte = job.position[7:0];
      6'd19:                     cur_byte = job.speed[31:24];
      6'd20:                     cur_byte = job.speed[23:16];
      6'd21:                     cur_byte = job.speed[15:8];
      6'd22:                     cur_byte = job.speed[7:0];
      6'd23:                     cur_byte = job.start_slope[31:24];
      6'd24:                     cur_byte = job.start_slope[23:16];
      6'd25:                     cur_byte = job.start_slope[15:8];
      6'd26:                     cur_byte = job.start_slope[7:0];
      6'd27:                     cur_byte = job.stop_slope[31:24];
      6'd28:                     cur_byte = job.stop_slope[23:16];
      6'd29:                     cur_byte = job.stop_slope[15:8];
      6'd30:                     cur_byte = job.stop_slope[7:0];
      6'd33:                     cur_byte = {6'b0, job.run_current[9:8]};
      6'd34:                     cur_byte = job.run_current[7:0];
      6'd38:                     cur_byte = msfb_pkg::TRIGGER_LO;
      6'd39:                     cur_byte = crc[7:0];
      6'd40:                     cur_byte = crc[15:8];
      default:                   cur_byte = 8'h00;
    endcase
  end

  assign crc_next = crc_update((idx == '0) ? msfb_pkg::CRC_INIT : crc, cur_byte);
  assign advance  = q_status.valid && (!res_valid || res_ready);
  assign at_last  = (idx == msfb_pkg::LAST_IDX);
  assign pop      = advance && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      res_valid <= 1'b0;
    end else if (advance) begin
      idx       <= at_last ? '0 : idx + 1'b1;
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_payload.frame_byte <= cur_byte;
      res_payload.byte_index <= idx;
      res_payload.last_byte  <= at_last;
      if (idx < msfb_pkg::IDX_W'(msfb_pkg::CRC_SPAN)) begin
        crc <= crc_next;
      end
    end
  end

endmodule

### design/msfb_check.sv
// Port-level checker for the stepper frame builder, bound to the top level
`timescale 1ns / 1ps
`include "modbus_stepper_frame_builder_assert.svh"
module msfb_check (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] frame_byte,
  input logic [5:0] byte_index,
  input logic       last_byte
);

  logic [5:0] exp_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_idx <= '0;
    end else if (res_valid && res_ready) begin
      exp_idx <= (exp_idx == msfb_pkg::LAST_IDX) ? '0 : exp_idx + 1'b1;
    end
  end

  `MSFB_ASSERT_NOW(a_index_in_order, res_valid, byte_index == exp_idx)
  `MSFB_ASSERT_NOW(a_last_on_crc_hi, res_valid && last_byte, byte_index == msfb_pkg::LAST_IDX)
  `MSFB_ASSERT_NOW(a_func_code, res_valid && byte_index == 6'd1, frame_byte == msfb_pkg::FUNC_WRITE_MULTI)
  `MSFB_ASSERT_NEXT(a_stall_holds, res_valid && !res_ready, res_valid && $stable(frame_byte) && $stable(byte_index))

endmodule

bind modbus_stepper_frame_builder msfb_check u_msfb_check (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .frame_byte (res.payload.frame_byte),
  .byte_index (res.payload.byte_index),
  .last_byte  (res.payload.last_byte)
);
